/* hdl/mlr_pkg.sv */
`default_nettype none

package mlr_pkg;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Extra bits that the signed decision term needs over a coordinate:
  // one for the sign and two for the doubled spans.
  localparam int unsigned DECISION_GUARD_BITS = 3;

endpackage

`default_nettype wire

/* hdl/mlr_if.sv */
`default_nettype none

// Input channel: one load or step item.
interface mlr_in_if #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned COLOUR_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [COORD_BITS-1:0]  x_start;
  logic [COORD_BITS-1:0]  y_start;
  logic [COORD_BITS-1:0]  x_end;
  logic [COORD_BITS-1:0]  y_end;
  logic [COLOUR_BITS-1:0] colour_in;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end, colour_in,
    input  ready
  );
  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end, colour_in,
    output ready
  );
endinterface

// Result channel: one pixel item.
interface mlr_out_if #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned COLOUR_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  pixel_x;
  logic [COORD_BITS-1:0]  pixel_y;
  logic [COLOUR_BITS-1:0] pixel_colour;
  logic                   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/midpoint_line_rasterizer_core.sv */
// A step item passes from the input register through the decision update into
// the result register, where its pixel is shown until the output takes it.
// Throughput: one item per cycle, load or step, while the result channel is not
// stalled; the decision update between the two registers is combinational.
// Reset: rst_n is synchronous and active low; it empties both registers and
// leaves the rasterizer idle, so a step before the first load gives no pixel.
`default_nettype none

module midpoint_line_rasterizer_core #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned COLOUR_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mlr_in_if.sink     in_chan,
  mlr_out_if.source  out_chan
);

  localparam int unsigned DW = COORD_BITS + mlr_pkg::DECISION_GUARD_BITS;

  // ------------------------------------------------------------------------
  // Input register. An item waits here until the result register can take
  // whatever it produces, and then moves on.
  // ------------------------------------------------------------------------
  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic [COORD_BITS-1:0]  s1_xs_r;
  logic [COORD_BITS-1:0]  s1_ys_r;
  logic [COORD_BITS-1:0]  s1_xe_r;
  logic [COORD_BITS-1:0]  s1_ye_r;
  logic [COLOUR_BITS-1:0] s1_colour_r;

  logic out_valid_r;
  logic out_free;
  logic advance;

  // The result register is free when empty or being drained this cycle.
  // Every item in the input register can move on then, including loads and
  // idle steps that give no pixel.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign advance       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_func_r   <= in_chan.func;
      s1_xs_r     <= in_chan.x_start;
      s1_ys_r     <= in_chan.y_start;
      s1_xe_r     <= in_chan.x_end;
      s1_ye_r     <= in_chan.y_end;
      s1_colour_r <= in_chan.colour_in;
    end
  end

  // ------------------------------------------------------------------------
  // Line state.
  // ------------------------------------------------------------------------
  logic                   busy_r;
  logic [COORD_BITS-1:0]  major_pos_r;
  logic [COORD_BITS-1:0]  major_end_r;
  logic [COORD_BITS-1:0]  minor_pos_r;
  logic [COORD_BITS-1:0]  minor_low_r;
  logic [COORD_BITS-1:0]  minor_high_r;
  logic [COORD_BITS-1:0]  major_span_r;
  logic [COORD_BITS-1:0]  minor_span_r;
  logic [DW-1:0]          decision_r;
  logic                   steep_r;
  logic                   mirror_r;
  logic [COLOUR_BITS-1:0] colour_r;

  // ------------------------------------------------------------------------
  // Load setup: order the endpoints so x rises, fold a falling line onto a
  // rising one, and pick the major axis.
  // ------------------------------------------------------------------------
  logic                  swap_ends;
  logic [COORD_BITS-1:0] xa, xb, ya0, yb0, ya, yb;
  logic                  ld_mirror;
  logic [COORD_BITS-1:0] ld_dx, ld_dy;
  logic                  ld_steep;
  logic [COORD_BITS-1:0] ld_major_pos, ld_major_end;
  logic [COORD_BITS-1:0] ld_minor_low, ld_minor_high;
  logic [COORD_BITS-1:0] ld_major_span, ld_minor_span;
  logic [DW-1:0]         ld_decision;

  always_comb begin
    swap_ends = s1_xe_r < s1_xs_r;
    xa  = swap_ends ? s1_xe_r : s1_xs_r;
    xb  = swap_ends ? s1_xs_r : s1_xe_r;
    ya0 = swap_ends ? s1_ye_r : s1_ys_r;
    yb0 = swap_ends ? s1_ys_r : s1_ye_r;

    ld_mirror = yb0 < ya0;
    ya = ld_mirror ? yb0 : ya0;
    yb = ld_mirror ? ya0 : yb0;

    ld_dx    = xb - xa;
    ld_dy    = yb - ya;
    // A slope of exactly one stays on the x axis.
    ld_steep = ld_dy > ld_dx;

    if (ld_steep) begin
      ld_major_pos  = ya;
      ld_major_end  = yb;
      ld_minor_low  = xa;
      ld_minor_high = xb;
      ld_major_span = ld_dy;
      ld_minor_span = ld_dx;
    end else begin
      ld_major_pos  = xa;
      ld_major_end  = xb;
      ld_minor_low  = ya;
      ld_minor_high = yb;
      ld_major_span = ld_dx;
      ld_minor_span = ld_dy;
    end

    // Midpoint decision at twice its exact value, so the half-unit term
    // stays whole: major_span - 2 * minor_span.
    ld_decision = {3'b000, ld_major_span} - {2'b00, ld_minor_span, 1'b0};
  end

  // ------------------------------------------------------------------------
  // Step: emit the current pixel, then advance along the major axis. A
  // negative decision means the line passed the midpoint, so the minor
  // coordinate moves too; a decision of exactly zero holds it.
  // ------------------------------------------------------------------------
  logic [COORD_BITS-1:0] minor_out;
  logic [COORD_BITS-1:0] st_px, st_py;
  logic                  st_last;
  logic                  dec_neg;
  logic [DW-1:0]         dec_up, dec_down;
  logic                  do_load, do_step;

  always_comb begin
    minor_out = mirror_r ? (minor_low_r + minor_high_r - minor_pos_r) : minor_pos_r;
    st_px     = steep_r ? minor_out : major_pos_r;
    st_py     = steep_r ? major_pos_r : minor_out;
    st_last   = major_pos_r == major_end_r;
    dec_neg   = decision_r[DW-1];
    dec_up    = decision_r + ({2'b00, major_span_r, 1'b0} - {2'b00, minor_span_r, 1'b0});
    dec_down  = decision_r - {2'b00, minor_span_r, 1'b0};
  end

  assign do_load = advance && (s1_func_r == mlr_pkg::FUNC_LOAD);
  assign do_step = advance && (s1_func_r == mlr_pkg::FUNC_STEP) && busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (do_load) begin
      busy_r <= 1'b1;
    end else if (do_step && st_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      major_pos_r  <= ld_major_pos;
      major_end_r  <= ld_major_end;
      minor_pos_r  <= ld_minor_low;
      minor_low_r  <= ld_minor_low;
      minor_high_r <= ld_minor_high;
      major_span_r <= ld_major_span;
      minor_span_r <= ld_minor_span;
      decision_r   <= ld_decision;
      steep_r      <= ld_steep;
      mirror_r     <= ld_mirror;
      colour_r     <= s1_colour_r;
    end else if (do_step && !st_last) begin
      major_pos_r <= major_pos_r + 1'b1;
      if (dec_neg) begin
        minor_pos_r <= minor_pos_r + 1'b1;
        decision_r  <= dec_up;
      end else begin
        decision_r  <= dec_down;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result register.
  // ------------------------------------------------------------------------
  logic [COORD_BITS-1:0]  px_r;
  logic [COORD_BITS-1:0]  py_r;
  logic [COLOUR_BITS-1:0] pcol_r;
  logic                   plast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= do_step;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      px_r    <= st_px;
      py_r    <= st_py;
      pcol_r  <= colour_r;
      plast_r <= st_last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_x      = px_r;
  assign out_chan.pixel_y      = py_r;
  assign out_chan.pixel_colour = pcol_r;
  assign out_chan.last_pixel   = plast_r;

endmodule

`default_nettype wire

/* hdl/mlr_checker.sv */
`default_nettype none

module mlr_checker #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned COLOUR_BITS = 32
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_BITS-1:0]  pixel_x,
  input wire logic [COORD_BITS-1:0]  pixel_y,
  input wire logic [COLOUR_BITS-1:0] pixel_colour,
  input wire logic                   last_pixel
);

  // A stalled pixel must stay put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_colour) && $stable(last_pixel))
    else $error("pixel changed while stalled");

  // Reset leaves the result channel empty.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel shown right after reset");

  // A pixel appearing on an empty channel comes from an item taken on the input
  // channel that passed through the input register.
  a_pixel_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("pixel without a matching step item");

  // With nothing waiting on the output, the block always takes an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

endmodule

bind midpoint_line_rasterizer_core mlr_checker #(
  .COORD_BITS  (COORD_BITS),
  .COLOUR_BITS (COLOUR_BITS)
) u_mlr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .pixel_x      (out_chan.pixel_x),
  .pixel_y      (out_chan.pixel_y),
  .pixel_colour (out_chan.pixel_colour),
  .last_pixel   (out_chan.last_pixel)
);

`default_nettype wire
